FILE: src/sor_pkg.sv
// ----------------------------------------------------------------------------
// sor_pkg
// shared constants, types and helpers for the spiral order reader
// ----------------------------------------------------------------------------
package sor_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 4;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int TOTAL_W = ADDR_W + 1;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    typedef enum logic [1:0] {
        D_RIGHT = 2'b00,
        D_DOWN  = 2'b01,
        D_LEFT  = 2'b10,
        D_UP    = 2'b11
    } t_dir;

    function automatic logic [COUNT_W-1:0] clamp_count(
        input logic [COUNT_W-1:0] v,
        input logic [COUNT_W-1:0] hi
    );
        logic [COUNT_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = COUNT_W'(1);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

FILE: src/spiral_order_reader_top.sv
// after the item completing the matrix is accepted, the state register moves to emitting
// and results come through the store's registered read port, one result per cycle
// items are taken while loading whenever i_start is high; busy is high while emitting
// reset: synchronous active low, counts return to 8 x 8 and loading restarts
// the receiver cannot stall: each result is shown for one cycle under o_valid
// ----------------------------------------------------------------------------
// spiral_order_reader_top
// stores a matrix in row-major order and reads it back in clockwise spiral
// order from an element store with one write port and one registered read port, a two-port store
// ----------------------------------------------------------------------------
module spiral_order_reader_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [sor_pkg::DATA_W-1:0]    i_value,
    input  logic                                 i_wr_en,
    input  logic                                 i_wr_index,
    input  logic        [sor_pkg::COUNT_W-1:0]   i_wr_data,
    output logic                                 o_valid,
    output logic signed [sor_pkg::DATA_W-1:0]    o_out_value,
    output logic                                 o_is_last
);

    localparam logic [sor_pkg::COUNT_W-1:0] ROW_HI = sor_pkg::COUNT_W'(sor_pkg::MAX_ROWS);
    localparam logic [sor_pkg::COUNT_W-1:0] COL_HI = sor_pkg::COUNT_W'(sor_pkg::MAX_COLS);

    logic [sor_pkg::DATA_W-1:0] mem [sor_pkg::STORE_DEPTH];

    sor_pkg::t_state                 r_state, n_state;
    sor_pkg::t_dir                   r_dir, n_dir;
    logic [sor_pkg::COUNT_W-1:0]     r_rows, n_rows;
    logic [sor_pkg::COUNT_W-1:0]     r_cols, n_cols;
    logic [sor_pkg::ADDR_W-1:0]      r_load_cnt, n_load_cnt;
    logic [sor_pkg::ADDR_W-1:0]      r_emit_cnt, n_emit_cnt;
    logic [sor_pkg::ROW_W-1:0]       r_row, n_row, r_top, n_top, r_bottom, n_bottom;
    logic [sor_pkg::COL_W-1:0]       r_col, n_col, r_left, n_left, r_right, n_right;
    logic                            r_valid, n_valid;
    logic                            r_last, n_last;
    logic [sor_pkg::DATA_W-1:0]      r_rd_data;

    logic                            accept;
    logic                            load_done;
    logic                            emit_last;
    logic [sor_pkg::TOTAL_W-1:0]     total;
    logic [sor_pkg::TOTAL_W-1:0]     rd_index;
    logic [sor_pkg::ADDR_W-1:0]      rd_addr;

    assign o_busy      = (r_state == sor_pkg::S_EMIT);
    assign o_valid     = r_valid;
    assign o_out_value = r_rd_data;
    assign o_is_last   = r_last;

    assign accept    = i_start && !o_busy;
    assign total     = sor_pkg::TOTAL_W'(r_rows) * sor_pkg::TOTAL_W'(r_cols);
    assign load_done = ((sor_pkg::TOTAL_W'(r_load_cnt) + sor_pkg::TOTAL_W'(1)) == total);
    assign emit_last = ((sor_pkg::TOTAL_W'(r_emit_cnt) + sor_pkg::TOTAL_W'(1)) == total);
    assign rd_index  = sor_pkg::TOTAL_W'(r_row) * sor_pkg::TOTAL_W'(r_cols)
                     + sor_pkg::TOTAL_W'(r_col);
    assign rd_addr   = rd_index[sor_pkg::ADDR_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_dir      = r_dir;
        n_rows     = r_rows;
        n_cols     = r_cols;
        n_load_cnt = r_load_cnt;
        n_emit_cnt = r_emit_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_top      = r_top;
        n_bottom   = r_bottom;
        n_left     = r_left;
        n_right    = r_right;
        n_valid    = 1'b0;
        n_last     = 1'b0;

        if (i_wr_en) begin
            if (i_wr_index == sor_pkg::REG_ROW_COUNT) begin
                n_rows = sor_pkg::clamp_count(i_wr_data, ROW_HI);
            end else begin
                n_cols = sor_pkg::clamp_count(i_wr_data, COL_HI);
            end
            n_load_cnt = '0;
        end

        unique case (r_state)
            sor_pkg::S_LOAD: begin
                if (accept) begin
                    if (load_done) begin
                        n_load_cnt = '0;
                        n_emit_cnt = '0;
                        n_state    = sor_pkg::S_EMIT;
                        n_dir      = sor_pkg::D_RIGHT;
                        n_row      = '0;
                        n_col      = '0;
                        n_top      = '0;
                        n_left     = '0;
                        n_bottom   = sor_pkg::ROW_W'(r_rows - sor_pkg::COUNT_W'(1));
                        n_right    = sor_pkg::COL_W'(r_cols - sor_pkg::COUNT_W'(1));
                    end else begin
                        n_load_cnt = r_load_cnt + sor_pkg::ADDR_W'(1);
                    end
                end
            end
            sor_pkg::S_EMIT: begin
                n_valid    = 1'b1;
                n_last     = emit_last;
                n_emit_cnt = r_emit_cnt + sor_pkg::ADDR_W'(1);
                if (emit_last) begin
                    n_state = sor_pkg::S_LOAD;
                end
                // walk one step, turning and shrinking the finished side at a corner
                unique case (r_dir)
                    sor_pkg::D_RIGHT: begin
                        if (r_col != r_right) begin
                            n_col = r_col + sor_pkg::COL_W'(1);
                        end else begin
                            n_top = r_top + sor_pkg::ROW_W'(1);
                            n_row = r_row + sor_pkg::ROW_W'(1);
                            n_dir = sor_pkg::D_DOWN;
                        end
                    end
                    sor_pkg::D_DOWN: begin
                        if (r_row != r_bottom) begin
                            n_row = r_row + sor_pkg::ROW_W'(1);
                        end else begin
                            n_right = r_right - sor_pkg::COL_W'(1);
                            n_col   = r_col - sor_pkg::COL_W'(1);
                            n_dir   = sor_pkg::D_LEFT;
                        end
                    end
                    sor_pkg::D_LEFT: begin
                        if (r_col != r_left) begin
                            n_col = r_col - sor_pkg::COL_W'(1);
                        end else begin
                            n_bottom = r_bottom - sor_pkg::ROW_W'(1);
                            n_row    = r_row - sor_pkg::ROW_W'(1);
                            n_dir    = sor_pkg::D_UP;
                        end
                    end
                    sor_pkg::D_UP: begin
                        if (r_row != r_top) begin
                            n_row = r_row - sor_pkg::ROW_W'(1);
                        end else begin
                            n_left = r_left + sor_pkg::COL_W'(1);
                            n_col  = r_col + sor_pkg::COL_W'(1);
                            n_dir  = sor_pkg::D_RIGHT;
                        end
                    end
                    default: begin
                        n_dir = sor_pkg::D_RIGHT;
                    end
                endcase
            end
            default: begin
                n_state = sor_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sor_pkg::S_LOAD;
            r_dir      <= sor_pkg::D_RIGHT;
            r_rows     <= ROW_HI;
            r_cols     <= COL_HI;
            r_load_cnt <= '0;
            r_emit_cnt <= '0;
            r_valid    <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dir      <= n_dir;
            r_rows     <= n_rows;
            r_cols     <= n_cols;
            r_load_cnt <= n_load_cnt;
            r_emit_cnt <= n_emit_cnt;
            r_valid    <= n_valid;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_top    <= n_top;
        r_bottom <= n_bottom;
        r_left   <= n_left;
        r_right  <= n_right;
    end

    // element store: one write port for loading, one registered read for emitting
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_load_cnt] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_busy) begin
            r_rd_data <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (sor_pkg::TOTAL_W'(r_emit_cnt) < total))
        else $error("emit count beyond matrix size");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (sor_pkg::TOTAL_W'(r_load_cnt) < total))
        else $error("load count beyond matrix size");

    a_busy_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("emission began without an item");

    a_end_flags_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> (o_valid && o_is_last))
        else $error("end of emission without last item");

    a_nothing_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_last |=> !o_valid)
        else $error("item after last of run");
`endif

endmodule
